// ===== hw/rtl/array_list_table_macros.svh =====
// ----------------------------------------------------------------------------
// array_list_table assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_TABLE_MACROS_SVH
`define ARRAY_LIST_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define ALT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/alt_pkg.sv =====
// ----------------------------------------------------------------------------
// alt_pkg
// Types and constants shared by the list cells and the list controller.
// ----------------------------------------------------------------------------
package alt_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int KEY_W      = 32;
    localparam int AGE_W      = 8;
    localparam int POS_W      = 5;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;
    localparam int IN_W       = 56;
    localparam int OUT_W      = 48;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_READ   = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_SWAP   = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [AGE_W-1:0] age;
    } t_entry;

    typedef struct packed {
        logic   append;
        logic   remove;
        logic   swap;
        t_idx   idx_a;
        t_idx   idx_b;
        t_cnt   count;
        t_entry new_entry;
        t_entry bus_a;
        t_entry bus_b;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/alt_cell.sv =====
// ----------------------------------------------------------------------------
// alt_cell
// One list place: holds an entry, loads, shifts from its neighbour or swaps.
// ----------------------------------------------------------------------------
module alt_cell (
    input  logic              i_clk,
    input  alt_pkg::t_cell_cmd i_cmd,
    input  alt_pkg::t_idx     i_cell_idx,
    input  alt_pkg::t_entry   i_next,
    output alt_pkg::t_entry   o_entry,
    output alt_pkg::t_entry   o_tap_a,
    output alt_pkg::t_entry   o_tap_b
);
    import alt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   sel_a;
    logic   sel_b;
    logic   behind;

    assign sel_a  = (i_cell_idx == i_cmd.idx_a);
    assign sel_b  = (i_cell_idx == i_cmd.idx_b);
    assign behind = (i_cell_idx >= i_cmd.idx_a) &&
                    ((CNT_W'(i_cell_idx) + CNT_W'(1)) < i_cmd.count);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.append && sel_a) begin
            n_entry = i_cmd.new_entry;
        end else if (i_cmd.remove && behind) begin
            n_entry = i_next;
        end else if (i_cmd.swap && sel_a) begin
            n_entry = i_cmd.bus_b;
        end else if (i_cmd.swap && sel_b) begin
            n_entry = i_cmd.bus_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap_a = sel_a ? r_entry : '0;
    assign o_tap_b = sel_b ? r_entry : '0;

endmodule

// ===== hw/rtl/array_list_table.sv =====
// ----------------------------------------------------------------------------
// array_list_table
// Fixed-capacity list of key/age entries held in a row of cells.
// ----------------------------------------------------------------------------
// Output: each result word is registered when its request word is taken.
// Throughput: one request per cycle while results are taken; the cell row settles
// each request, and a result left waiting holds off the input.
// Reset: synchronous, active low; clears the entry count and the output valid.
// Stored entries are not cleared and are only read once written.
// ----------------------------------------------------------------------------
`include "array_list_table_macros.svh"

module array_list_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // req_type[2:0], entry_key[34:3], entry_age[42:35], position[47:43],
    // other_position[52:48], zero fill [55:53]
    input  logic [alt_pkg::IN_W-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // status[1:0], got_key[33:2], got_age[41:34], entry_count[46:42],
    // is_empty[47]
    output logic [alt_pkg::OUT_W-1:0] o_m_tdata
);
    import alt_pkg::*;

    logic                    s_acc;
    t_req                    req;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        pos2;
    logic [POS_W-1:0]        pos_m1;
    logic [POS_W-1:0]        pos2_m1;
    logic                    pos_ok;
    logic                    pos2_ok;
    t_cell_cmd               cmd;
    t_entry                  bus_a;
    t_entry                  bus_b;
    t_entry                  cell_out [LIST_DEPTH];
    t_entry                  tap_a    [LIST_DEPTH];
    t_entry                  tap_b    [LIST_DEPTH];
    t_entry                  next_in  [LIST_DEPTH];

    t_cnt                    r_count;
    t_cnt                    n_count;
    logic                    r_out_valid;
    t_status                 r_out_status;
    t_status                 n_status;
    t_entry                  r_out_entry;
    t_entry                  n_got;
    t_cnt                    r_out_count;
    logic                    r_out_empty;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign req     = t_req'(i_s_tdata[2:0]);
    assign pos     = i_s_tdata[47:43];
    assign pos2    = i_s_tdata[52:48];
    assign pos_m1  = pos - POS_W'(1);
    assign pos2_m1 = pos2 - POS_W'(1);
    assign pos_ok  = (pos != '0) && (CNT_W'(pos) <= r_count);
    assign pos2_ok = (pos2 != '0) && (CNT_W'(pos2) <= r_count);

    always_comb begin
        bus_a = '0;
        bus_b = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            bus_a = bus_a | tap_a[i];
            bus_b = bus_b | tap_b[i];
        end
    end

    always_comb begin
        n_count       = r_count;
        n_status      = ST_INVALID;
        n_got         = '0;
        cmd.append    = 1'b0;
        cmd.remove    = 1'b0;
        cmd.swap      = 1'b0;
        cmd.idx_a     = pos_m1[IDX_W-1:0];
        cmd.idx_b     = pos2_m1[IDX_W-1:0];
        cmd.count     = r_count;
        cmd.new_entry = t_entry'({i_s_tdata[34:3], i_s_tdata[42:35]});
        cmd.bus_a     = bus_a;
        cmd.bus_b     = bus_b;
        case (req)
            REQ_CLEAR: begin
                n_count  = '0;
                n_status = ST_DONE;
            end
            REQ_APPEND: begin
                cmd.idx_a = r_count[IDX_W-1:0];
                if (r_count >= CNT_W'(LIST_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.append = s_acc;
                    n_count    = r_count + CNT_W'(1);
                    n_status   = ST_DONE;
                end
            end
            REQ_READ: begin
                if (pos_ok) begin
                    n_got    = bus_a;
                    n_status = ST_DONE;
                end
            end
            REQ_REMOVE: begin
                if (pos_ok) begin
                    n_got      = bus_a;
                    cmd.remove = s_acc;
                    n_count    = r_count - CNT_W'(1);
                    n_status   = ST_DONE;
                end
            end
            REQ_SWAP: begin
                if (pos_ok && pos2_ok) begin
                    cmd.swap = s_acc;
                    n_status = ST_DONE;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cells
        if (g == LIST_DEPTH - 1) begin : g_last
            assign next_in[g] = '0;
        end else begin : g_mid
            assign next_in[g] = cell_out[g+1];
        end

        alt_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_cell_idx (IDX_W'(g)),
            .i_next     (next_in[g]),
            .o_entry    (cell_out[g]),
            .o_tap_a    (tap_a[g]),
            .o_tap_b    (tap_b[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_status <= n_status;
            r_out_entry  <= n_got;
            r_out_count  <= n_count;
            r_out_empty  <= (n_count == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_empty, r_out_count, r_out_entry.age, r_out_entry.key,
                         r_out_status};

    `ALT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(LIST_DEPTH), "count over depth")
    `ALT_ASSERT(a_stall_blocks, i_clk, i_rst_n, (r_out_valid && !i_m_tready) |-> !o_s_tready, "input taken while result stalled")
    `ALT_ASSERT(a_clear_count, i_clk, i_rst_n, (s_acc && req == REQ_CLEAR) |=> (r_count == '0), "clear left entries")
    `ALT_ASSERT(a_append_count, i_clk, i_rst_n, (s_acc && req == REQ_APPEND && r_count < CNT_W'(LIST_DEPTH)) |=> (r_count == $past(r_count) + CNT_W'(1)), "append did not grow list")
    `ALT_ASSERT(a_result_count, i_clk, i_rst_n, s_acc |=> (r_out_count == r_count), "reported count differs from held count")
    `ALT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule
